### design/lfht_pkg.sv
// ----------------------------------------------------------------------------
// lfht_pkg
// Shared types and codes for the lowest free handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package lfht_pkg;

    // Command codes
    localparam logic [1:0] CMD_CREATE  = 2'd0;
    localparam logic [1:0] CMD_DESTROY = 2'd1;
    localparam logic [1:0] CMD_LOOKUP  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Input beat
    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot_index;
        logic [31:0] object_value;
    } item_t;

    // Result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  result_index;
        logic [31:0] result_object;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;  // write zero at the pointer and advance it
        logic load;      // capture the input beat and read its slot
        logic eval;      // execute the held command and load the result
        logic scan_rd;   // read the slot that the pointer names
        logic scan_inc;  // advance the pointer past an occupied slot
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;    // pointer at the last slot during clearing
        logic out_busy;    // result register holds an untaken beat
        logic scan_start;  // held create succeeds and needs a pointer scan
        logic ptr_full;    // pointer equals the slot count
        logic rd_zero;     // slot read back is empty
    } sts_t;

endpackage

`default_nettype wire

### design/lowest_free_handle_table_top.sv
// ----------------------------------------------------------------------------
// lowest_free_handle_table_top
// Handle table that hands out the lowest free slot on create.
// ----------------------------------------------------------------------------
// Usage: send create, destroy or lookup beats on the s_ channel; each one
// returns exactly one result beat on the m_ channel, in order.
// Execution: the slot memory is read into a register on the accepting edge;
// the command executes in S_EVAL, once the result register is free, and
// loads the result.
// Flow: no new command is taken until the held one has executed. A
// successful create then scans for the next empty slot, one memory read and
// one check per slot tested, until an empty slot or the end of the table is
// reached; no command is taken during the scan.
// Reset: after aresetn the block clears the slot memory, one slot a cycle,
// with s_ready low; the first-free pointer starts at 0.
// Stall: the result register holds a beat until m_ready; the block takes the
// next command meanwhile and waits to execute it until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_handle_table_top #(
    parameter int TABLE_SLOTS = 16,
    parameter int OBJECT_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lfht_pkg::item_t   s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lfht_pkg::result_t      m_payload
);

    lfht_pkg::cmd_t cmd;
    lfht_pkg::sts_t sts;

    // Sequencer
    lfht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table datapath
    lfht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .OBJECT_BITS (OBJECT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

### design/lfht_ctrl.sv
// ----------------------------------------------------------------------------
// lfht_ctrl
// Sequencer for clearing, command execution and the first-free scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lfht_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lfht_pkg::sts_t sts,
    output lfht_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_CHECK = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Hold state, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!sts.out_busy) begin
                    cmd.eval   = 1'b1;
                    state_next = sts.scan_start ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                if (sts.ptr_full) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.rd_zero) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/lfht_dp.sv
// ----------------------------------------------------------------------------
// lfht_dp
// Slot memory, first-free pointer, held command and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfht_dp #(
    parameter int TABLE_SLOTS = 16,
    parameter int OBJECT_BITS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lfht_pkg::item_t  s_payload,
    output lfht_pkg::result_t     m_payload,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire lfht_pkg::cmd_t   cmd,
    output lfht_pkg::sts_t        sts
);

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PW = $clog2(TABLE_SLOTS + 1);
    localparam logic [PW-1:0] PTR_FULL = PW'(TABLE_SLOTS);
    localparam logic [PW-1:0] PTR_LAST = PW'(TABLE_SLOTS - 1);

    logic [OBJECT_BITS-1:0] mem [TABLE_SLOTS];
    logic [OBJECT_BITS-1:0] rdata_reg;
    logic [PW-1:0]          ptr_reg, ptr_next;
    lfht_pkg::item_t        item_reg;
    lfht_pkg::result_t      out_reg, out_next;
    logic                   out_valid_reg;

    logic [AW-1:0]          s_addr;
    logic [AW-1:0]          item_addr;
    logic [AW-1:0]          ptr_addr;
    logic [OBJECT_BITS-1:0] item_obj;
    logic                   idx_ok;
    logic                   slot_used;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [OBJECT_BITS-1:0] wr_data;

    assign s_addr    = AW'(s_payload.slot_index);
    assign item_addr = AW'(item_reg.slot_index);
    assign ptr_addr  = AW'(ptr_reg);
    assign item_obj  = OBJECT_BITS'(item_reg.object_value);
    assign idx_ok    = 32'(item_reg.slot_index) < 32'(TABLE_SLOTS);
    assign slot_used = idx_ok && (rdata_reg != '0);

    // Status to the controller
    assign sts.clr_last   = (ptr_reg == PTR_LAST);
    assign sts.out_busy   = out_valid_reg && !m_ready;
    assign sts.scan_start = (item_reg.command == lfht_pkg::CMD_CREATE)
                            && (item_obj != '0) && (ptr_reg != PTR_FULL);
    assign sts.ptr_full   = (ptr_reg == PTR_FULL);
    assign sts.rd_zero    = (rdata_reg == '0);

    // Clear step, scan advance, or execute the held command: result, pointer and memory write
    always_comb begin
        out_next = '0;
        ptr_next = ptr_reg;
        wr_en    = 1'b0;
        wr_addr  = ptr_addr;
        wr_data  = '0;
        if (cmd.clr_step) begin
            wr_en    = 1'b1;
            ptr_next = sts.clr_last ? '0 : ptr_reg + PW'(1);
        end else if (cmd.scan_inc) begin
            ptr_next = ptr_reg + PW'(1);
        end else if (cmd.eval) begin
            case (item_reg.command)
                lfht_pkg::CMD_CREATE: begin
                    if (item_obj == '0) begin
                        out_next.status = lfht_pkg::ST_ZERO;
                    end else if (ptr_reg == PTR_FULL) begin
                        out_next.status = lfht_pkg::ST_FULL;
                    end else begin
                        out_next.status       = lfht_pkg::ST_OK;
                        out_next.result_index = 4'(ptr_reg);
                        wr_en    = 1'b1;
                        wr_data  = item_obj;
                        ptr_next = ptr_reg + PW'(1);
                    end
                end
                lfht_pkg::CMD_DESTROY: begin
                    if (slot_used) begin
                        out_next.status = lfht_pkg::ST_OK;
                        wr_en   = 1'b1;
                        wr_addr = item_addr;
                        if (PW'(item_addr) < ptr_reg) begin
                            ptr_next = PW'(item_addr);
                        end
                    end else begin
                        out_next.status = lfht_pkg::ST_EMPTY;
                    end
                end
                lfht_pkg::CMD_LOOKUP: begin
                    if (slot_used) begin
                        out_next.status        = lfht_pkg::ST_OK;
                        out_next.result_object = 32'(rdata_reg);
                    end else begin
                        out_next.status = lfht_pkg::ST_EMPTY;
                    end
                end
                default: begin
                    out_next.status = lfht_pkg::ST_EMPTY;
                end
            endcase
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.load) begin
            rdata_reg <= mem[s_addr];
        end else if (cmd.scan_rd) begin
            rdata_reg <= mem[ptr_addr];
        end
    end

    // Pointer and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ptr_reg <= ptr_next;
            if (cmd.eval) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held command and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_payload;
        end
        if (cmd.eval) begin
            out_reg <= out_next;
        end
    end

    assign m_payload = out_reg;
    assign m_valid   = out_valid_reg;

endmodule

`default_nettype wire

### dv/tb_lowest_free_handle_table_top.sv
// ----------------------------------------------------------------------------
// tb_lowest_free_handle_table_top
// Self-checking bench for the lowest free handle table.
// ----------------------------------------------------------------------------
// A short directed table covers the empty, full and zero-object cases and
// fills the table to the end. Random create, destroy and lookup traffic then
// drives the table back and forth between full and empty. Every command beat
// taken updates a shadow table here. The result beat it should produce goes
// into an in-order queue, and each result beat taken is compared with the
// head of that queue. Both sides idle at random, and the sink holds off once
// for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------

module tb_lowest_free_handle_table_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS  = 16;
    localparam int OBJECT_BITS  = 32;
    localparam int RANDOM_BEATS = 625;
    localparam int LONG_HOLD    = 300;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        lfht_pkg::item_t   beat;
        logic              typed;
        lfht_pkg::result_t want;
    } directed_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    lfht_pkg::item_t   s_payload = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    lfht_pkg::result_t m_payload;

    // shadow of the block's table and first-free pointer
    logic [31:0] table_objects [TABLE_SLOTS];
    int          lowest_free;

    lfht_pkg::result_t pending_results [$];
    int      beats_sent    = 0;
    int      results_taken = 0;
    int      error_count   = 0;
    bit      results_held  = 1'b0;

    lowest_free_handle_table_top #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .OBJECT_BITS (OBJECT_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Apply one command to the shadow table and return the result it yields.
    function automatic lfht_pkg::result_t apply_command(input lfht_pkg::item_t beat);
        lfht_pkg::result_t res;
        res = '0;
        case (beat.command)
            lfht_pkg::CMD_CREATE: begin
                // zero object wins over a full table
                if (beat.object_value == '0) begin
                    res.status = lfht_pkg::ST_ZERO;
                end else if (lowest_free >= TABLE_SLOTS) begin
                    res.status = lfht_pkg::ST_FULL;
                end else begin
                    res.status       = lfht_pkg::ST_OK;
                    res.result_index = 4'(lowest_free);
                    table_objects[lowest_free] = beat.object_value;
                    // bound first, then the slot
                    while (lowest_free < TABLE_SLOTS && table_objects[lowest_free] != '0)
                        lowest_free++;
                end
            end
            lfht_pkg::CMD_DESTROY: begin
                if (table_objects[beat.slot_index] != '0) begin
                    table_objects[beat.slot_index] = '0;
                    if (int'(beat.slot_index) < lowest_free)
                        lowest_free = int'(beat.slot_index);
                    res.status = lfht_pkg::ST_OK;
                end else begin
                    res.status = lfht_pkg::ST_EMPTY;
                end
            end
            lfht_pkg::CMD_LOOKUP: begin
                if (table_objects[beat.slot_index] != '0) begin
                    res.status        = lfht_pkg::ST_OK;
                    res.result_object = table_objects[beat.slot_index];
                end else begin
                    res.status = lfht_pkg::ST_EMPTY;
                end
            end
            default: res.status = lfht_pkg::ST_EMPTY;
        endcase
        return res;
    endfunction

    // Pick a random occupied slot, or any slot when the table is empty.
    function automatic logic [3:0] pick_occupied_slot();
        logic [3:0] hits [$];
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (table_objects[i] != '0)
                hits.push_back(4'(i));
        if (hits.size() == 0)
            return 4'($urandom_range(0, TABLE_SLOTS - 1));
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    function automatic directed_row_t mk_row(
        input logic [1:0] cmd, input logic [3:0] idx, input logic [31:0] obj,
        input logic typed, input logic [1:0] st, input logic [3:0] ri,
        input logic [31:0] ro
    );
        directed_row_t row;
        row.beat  = '{command: cmd, slot_index: idx, object_value: obj};
        row.typed = typed;
        row.want  = '{status: st, result_index: ri, result_object: ro};
        return row;
    endfunction

    // Offer one command beat after a random gap, hold it until taken.
    task automatic send_beat(input lfht_pkg::item_t beat, input logic typed,
                             input lfht_pkg::result_t want);
        int                gap;
        lfht_pkg::result_t predicted;
        gap = (results_held || ((beats_sent / 70) % 3 == 2)) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_command(beat);
        pending_results.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each result beat taken with the oldest pending one.
    always @(posedge aclk) begin : result_check
        lfht_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h",
                         $time, m_payload);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_payload.status));
                check_field("result_index", 32'(want.result_index),
                            32'(m_payload.result_index));
                check_field("result_object", want.result_object,
                            m_payload.result_object);
            end
        end
    end

    // Result sink: random stalls, quiet stretches, one long hold-off.
    initial begin : result_sink
        int stall;
        bit long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            if (!long_hold_done && results_taken >= 250) begin
                long_hold_done = 1'b1;
                results_held   = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                results_held = 1'b0;
            end else begin
                stall = ((results_taken / 60) % 3 == 1) ? 0 : $urandom_range(0, 19);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Command source: directed table, then random traffic, then drain.
    initial begin : command_source
        directed_row_t   directed_rows [$];
        lfht_pkg::item_t beat;
        int              roll;
        bit              fill_phase;

        for (int i = 0; i < TABLE_SLOTS; i++)
            table_objects[i] = '0;
        lowest_free = 0;

        directed_rows.push_back(mk_row(lfht_pkg::CMD_LOOKUP, 4'd15, '0, 1,
                                       lfht_pkg::ST_EMPTY, '0, '0));
        directed_rows.push_back(mk_row(lfht_pkg::CMD_DESTROY, 4'd15, 32'hFFFF_FFFF, 1,
                                       lfht_pkg::ST_EMPTY, '0, '0));
        directed_rows.push_back(mk_row(lfht_pkg::CMD_CREATE, 4'd15, '0, 1,
                                       lfht_pkg::ST_ZERO, '0, '0));
        directed_rows.push_back(mk_row(lfht_pkg::CMD_CREATE, 4'd9, 32'hFFFF_FFFF, 1,
                                       lfht_pkg::ST_OK, 4'd0, '0));
        directed_rows.push_back(mk_row(lfht_pkg::CMD_CREATE, 4'd0, 32'h0000_0001, 1,
                                       lfht_pkg::ST_OK, 4'd1, '0));
        directed_rows.push_back(mk_row(lfht_pkg::CMD_LOOKUP, 4'd0, '0, 1,
                                       lfht_pkg::ST_OK, '0, 32'hFFFF_FFFF));
        directed_rows.push_back(mk_row(CMD_UNUSED, 4'd15, 32'hFFFF_FFFF, 1,
                                       lfht_pkg::ST_EMPTY, '0, '0));
        // fill the rest of the table up to the last slot
        for (int k = 2; k < TABLE_SLOTS; k++)
            directed_rows.push_back(mk_row(lfht_pkg::CMD_CREATE, 4'(k),
                                           {16'(k), 16'hA5C3}, 0,
                                           lfht_pkg::ST_OK, '0, '0));
        directed_rows.push_back(mk_row(lfht_pkg::CMD_CREATE, 4'd0, 32'h0000_0005, 1,
                                       lfht_pkg::ST_FULL, '0, '0));
        // zero object on a full table still reports the zero object
        directed_rows.push_back(mk_row(lfht_pkg::CMD_CREATE, 4'd0, '0, 1,
                                       lfht_pkg::ST_ZERO, '0, '0));
        directed_rows.push_back(mk_row(lfht_pkg::CMD_DESTROY, 4'd7, '0, 1,
                                       lfht_pkg::ST_OK, '0, '0));
        directed_rows.push_back(mk_row(lfht_pkg::CMD_CREATE, 4'd0, 32'h8000_0000, 0,
                                       lfht_pkg::ST_OK, '0, '0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed,
                      directed_rows[i].want);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // pause once until every pending result has come back
            if (n == 400) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            // alternate create-heavy and destroy-heavy stretches
            fill_phase        = ((n / 48) % 2 == 0);
            roll              = $urandom_range(0, 99);
            beat.slot_index   = 4'($urandom_range(0, TABLE_SLOTS - 1));
            beat.object_value = $urandom;
            if (roll < 4) begin
                beat.command = CMD_UNUSED;
            end else if (roll < (fill_phase ? 64 : 34)) begin
                beat.command = lfht_pkg::CMD_CREATE;
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    beat.object_value = '0;
                else if (roll == 1)
                    beat.object_value = 32'($urandom_range(1, 15));
            end else begin
                beat.command = (roll < (fill_phase ? 80 : 74)) ? lfht_pkg::CMD_DESTROY
                                                               : lfht_pkg::CMD_LOOKUP;
                if ($urandom_range(0, 99) < 85)
                    beat.slot_index = pick_occupied_slot();
            end
            send_beat(beat, 1'b0, '0);
        end

        // drain, then allow the block's latency to pass
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (40) @(posedge aclk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : run_limit
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
